[src/nmea_rmc_time_checksum_parser_unit_assert.svh]
// Assertion helpers for the RMC parser unit.
// Both macros assume signals named clk and rst in the enclosing module.
`ifndef NMEA_RMC_TIME_CHECKSUM_PARSER_UNIT_ASSERT_SVH
`define NMEA_RMC_TIME_CHECKSUM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define NRMC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nrmc assertion failed");

// Next-cycle implication, disabled while in reset.
`define NRMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nrmc assertion failed");

`endif

[src/nrmc_pkg.sv]
`timescale 1ns / 1ps

package nrmc_pkg;

  // ASCII codes used by the sentence parser.
  localparam logic [7:0] ASCII_DOLLAR = 8'h24;
  localparam logic [7:0] ASCII_STAR   = 8'h2A;
  localparam logic [7:0] ASCII_DOT    = 8'h2E;
  localparam logic [7:0] ASCII_COMMA  = 8'h2C;
  localparam logic [7:0] ASCII_G      = 8'h47;
  localparam logic [7:0] ASCII_P      = 8'h50;
  localparam logic [7:0] ASCII_R      = 8'h52;
  localparam logic [7:0] ASCII_M      = 8'h4D;
  localparam logic [7:0] ASCII_C      = 8'h43;
  localparam logic [7:0] ASCII_0      = 8'h30;
  localparam logic [7:0] ASCII_9      = 8'h39;
  localparam logic [7:0] ASCII_UA     = 8'h41;
  localparam logic [7:0] ASCII_UF     = 8'h46;
  localparam logic [7:0] ASCII_LA     = 8'h61;
  localparam logic [7:0] ASCII_LF     = 8'h66;

  // Header "$GPRMC," length and the reset value of the zone offset.
  localparam logic [2:0] HEADER_LEN       = 3'd7;
  localparam logic [4:0] ZONE_OFFSET_INIT = 5'd8;

  // One decoded sentence result.
  typedef struct packed {
    logic [4:0] local_hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic       checksum_ok;
  } result_t;

endpackage

[src/nrmc_parser.sv]
`timescale 1ns / 1ps

module nrmc_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          in_char,
  input  logic [4:0]          zone_offset,
  output nrmc_pkg::result_t   result,
  output logic                result_valid
);

  // Parse phases.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_TIME   = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_HEX1   = 3'd4;
  localparam logic [2:0] PH_HEX2   = 3'd5;

  logic [2:0] phase, phase_next;
  logic [2:0] header_position, header_position_next;
  logic [7:0] running_xor, running_xor_next;
  logic [2:0] digit_count, digit_count_next;
  logic [6:0] hour_value, hour_value_next;
  logic [6:0] minute_value, minute_value_next;
  logic [6:0] second_value, second_value_next;
  logic [3:0] high_nibble, high_nibble_next;

  logic [4:0] hex_digit;
  logic [3:0] dec_digit;
  logic [7:0] hour_sum;

  // Expected header byte at a given position.
  function automatic logic [7:0] header_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = nrmc_pkg::ASCII_DOLLAR;
      3'd1:    ch = nrmc_pkg::ASCII_G;
      3'd2:    ch = nrmc_pkg::ASCII_P;
      3'd3:    ch = nrmc_pkg::ASCII_R;
      3'd4:    ch = nrmc_pkg::ASCII_M;
      3'd5:    ch = nrmc_pkg::ASCII_C;
      3'd6:    ch = nrmc_pkg::ASCII_COMMA;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Hex digit value in the low nibble; the top bit flags a non-hex byte.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= nrmc_pkg::ASCII_0 && c <= nrmc_pkg::ASCII_9) begin
      v = {1'b0, 4'(c - nrmc_pkg::ASCII_0)};
    end else if (c >= nrmc_pkg::ASCII_UA && c <= nrmc_pkg::ASCII_UF) begin
      v = {1'b0, 4'(c - nrmc_pkg::ASCII_UA + 8'd10)};
    end else if (c >= nrmc_pkg::ASCII_LA && c <= nrmc_pkg::ASCII_LF) begin
      v = {1'b0, 4'(c - nrmc_pkg::ASCII_LA + 8'd10)};
    end else begin
      v = 5'b10000;
    end
    return v;
  endfunction

  // Decimal shift-in: v * 10 + d, kept to seven bits.
  function automatic logic [6:0] mul10_add(input logic [6:0] v, input logic [3:0] d);
    logic [6:0] r;
    r = {v[3:0], 3'b000} + {v[5:0], 1'b0} + {3'b000, d};
    return r;
  endfunction

  // Reduce a sum below 168 modulo 24 with three compare-subtract steps.
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd96) r = r - 8'd96;
    if (r >= 8'd48) r = r - 8'd48;
    if (r >= 8'd24) r = r - 8'd24;
    return r[4:0];
  endfunction

  assign hex_digit = hex_value(in_char);
  assign dec_digit = (in_char >= nrmc_pkg::ASCII_0 && in_char <= nrmc_pkg::ASCII_9) ?
                     4'(in_char - nrmc_pkg::ASCII_0) : 4'd0;
  assign hour_sum  = {1'b0, hour_value} + {3'b000, zone_offset};

  // Result fields come straight from the current state and the incoming byte.
  assign result.local_hours = mod24(hour_sum);
  assign result.minutes     = minute_value;
  assign result.seconds     = second_value;
  assign result.checksum_ok = (running_xor == {high_nibble, hex_digit[3:0]});

  // Next-state logic for one byte.
  always_comb begin
    phase_next           = phase;
    header_position_next = header_position;
    running_xor_next     = running_xor;
    digit_count_next     = digit_count;
    hour_value_next      = hour_value;
    minute_value_next    = minute_value;
    second_value_next    = second_value;
    high_nibble_next     = high_nibble;
    result_valid         = 1'b0;

    if (in_char == nrmc_pkg::ASCII_DOLLAR) begin
      // A dollar sign restarts a sentence from any phase.
      phase_next           = PH_HEADER;
      header_position_next = 3'd1;
      running_xor_next     = 8'h00;
      digit_count_next     = 3'd0;
      hour_value_next      = 7'd0;
      minute_value_next    = 7'd0;
      second_value_next    = 7'd0;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (header_position < nrmc_pkg::HEADER_LEN &&
              in_char == header_char(header_position)) begin
            running_xor_next     = running_xor ^ in_char;
            header_position_next = header_position + 3'd1;
            if (header_position_next == nrmc_pkg::HEADER_LEN) begin
              phase_next = PH_TIME;
            end
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_TIME: begin
          if (in_char == nrmc_pkg::ASCII_STAR) begin
            phase_next = PH_HEX1;
          end else begin
            running_xor_next = running_xor ^ in_char;
            if (in_char == nrmc_pkg::ASCII_DOT || in_char == nrmc_pkg::ASCII_COMMA) begin
              phase_next = PH_BODY;
            end else begin
              // Non-digits count as a zero digit; digits past six are ignored.
              if (digit_count < 3'd2) begin
                hour_value_next = mul10_add(hour_value, dec_digit);
              end else if (digit_count < 3'd4) begin
                minute_value_next = mul10_add(minute_value, dec_digit);
              end else if (digit_count < 3'd6) begin
                second_value_next = mul10_add(second_value, dec_digit);
              end
              if (digit_count < 3'd6) begin
                digit_count_next = digit_count + 3'd1;
              end
            end
          end
        end
        PH_BODY: begin
          if (in_char == nrmc_pkg::ASCII_STAR) begin
            phase_next = PH_HEX1;
          end else begin
            running_xor_next = running_xor ^ in_char;
          end
        end
        PH_HEX1: begin
          if (!hex_digit[4]) begin
            high_nibble_next = hex_digit[3:0];
            phase_next       = PH_HEX2;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_HEX2: begin
          phase_next   = PH_IDLE;
          result_valid = !hex_digit[4];
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // State registers advance only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_position <= 3'd0;
      running_xor     <= 8'h00;
      digit_count     <= 3'd0;
      hour_value      <= 7'd0;
      minute_value    <= 7'd0;
      second_value    <= 7'd0;
      high_nibble     <= 4'd0;
    end else if (take) begin
      phase           <= phase_next;
      header_position <= header_position_next;
      running_xor     <= running_xor_next;
      digit_count     <= digit_count_next;
      hour_value      <= hour_value_next;
      minute_value    <= minute_value_next;
      second_value    <= second_value_next;
      high_nibble     <= high_nibble_next;
    end
  end

endmodule

[src/nmea_rmc_time_checksum_parser_unit.sv]
`timescale 1ns / 1ps
`include "nmea_rmc_time_checksum_parser_unit_assert.svh"

// RMC sentence time and checksum parser.
// Input channel: one ASCII byte per request on in_char, with in_valid/in_ready.
// Output channel: one request per complete "$GPRMC," sentence, carrying the
// local hour (UTC hour plus zone offset, modulo 24), minutes, seconds and a
// checksum match flag, with out_valid/out_ready.
// Configuration: cfg_wr_en writes cfg_wr_data into the zone offset register
// at the clock edge; write it only while no sentence is in flight.
// The result is registered and appears in the cycle after the second checksum
// digit is accepted. Throughput: one byte per cycle while in_ready is high; the
// parser state updates in the same cycle a byte is accepted and feeds a single output register.
// Stall: while a result waits with out_ready low, in_ready drops until it is
// taken; in_ready is high whenever the output register is empty or draining.
// Reset: rst (synchronous) returns the parser to waiting for a dollar sign,
// empties the output register and sets the zone offset to 8.
module nmea_rmc_time_checksum_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] local_hours,
  output logic [6:0] minutes,
  output logic [6:0] seconds,
  output logic       checksum_ok
);

  logic              take;
  logic [4:0]        zone_offset;
  nrmc_pkg::result_t result;
  logic              result_valid;
  nrmc_pkg::result_t out_reg;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Zone offset configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= nrmc_pkg::ZONE_OFFSET_INIT;
    end else if (cfg_wr_en) begin
      zone_offset <= cfg_wr_data;
    end
  end

  nrmc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_char      (in_char),
    .zone_offset  (zone_offset),
    .result       (result),
    .result_valid (result_valid)
  );

  // Output register: loads on an accepted byte that completes a sentence.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= result_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && result_valid) begin
      out_reg <= result;
    end
  end

  assign local_hours = out_reg.local_hours;
  assign minutes     = out_reg.minutes;
  assign seconds     = out_reg.seconds;
  assign checksum_ok = out_reg.checksum_ok;

  // Checks on the output stage and hour reduction.
  `NRMC_ASSERT_SAME(a_hours_in_range, out_valid, local_hours < 5'd24)
  `NRMC_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)
  `NRMC_ASSERT_SAME(a_result_from_byte, $rose(out_valid), $past(in_valid && in_ready))
  `NRMC_ASSERT_NEXT(a_dollar_no_result, in_valid && in_ready && in_char == nrmc_pkg::ASCII_DOLLAR, !$rose(out_valid))

endmodule
